// ===== src/filtered_pair_set_table_assert.svh =====
// Assertion macros used by the filtered pair set table datapath.
`ifndef FILTERED_PAIR_SET_TABLE_ASSERT_SVH
`define FILTERED_PAIR_SET_TABLE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FPST_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("fpst assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define FPST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("fpst assertion failed");

`endif

// ===== src/fpst_pkg.sv =====
// Package with types, constants and helpers of the filtered pair set table.
`default_nettype none

package fpst_pkg;

	localparam int MAX_PAIRS = 256;
	localparam int ADDR_W    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
	localparam int ENTRY_W   = 9;
	localparam int FMT_W     = 32;
	localparam int MOD_W     = 64;
	localparam int PAIR_W    = FMT_W + MOD_W;
	localparam int IN_DATA_W = ((PAIR_W + 7) / 8) * 8;
	localparam int OUT_W     = 3 + 1 + ENTRY_W + 1;
	localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [FMT_W-1:0] FMT_XR24 = 32'h3432_5258;
	localparam logic [FMT_W-1:0] FMT_AR24 = 32'h3432_5241;
	localparam logic [FMT_W-1:0] FMT_XB24 = 32'h3432_4258;
	localparam logic [FMT_W-1:0] FMT_AB24 = 32'h3432_4241;

	typedef enum logic [0:0] {
		CMD_ADD   = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_STORED      = 3'd0,
		ST_DUPLICATE   = 3'd1,
		ST_UNSUPPORTED = 3'd2,
		ST_FULL        = 3'd3,
		ST_QUERY       = 3'd4
	} status_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} ctrl_sts_t;

	function automatic logic fmt_known(input logic [FMT_W-1:0] code);
		return (code == FMT_XR24) || (code == FMT_AR24) ||
			(code == FMT_XB24) || (code == FMT_AB24);
	endfunction

endpackage

`default_nettype wire

// ===== src/fpst_ctrl.sv =====
// Controller state machine that sequences accept, table scan and result.
`default_nettype none

module fpst_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output fpst_pkg::ctrl_cmd_t     ctrl,
	input  wire fpst_pkg::ctrl_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_done) state_nxt = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign ctrl.load   = (state_q == S_IDLE) && in_valid;
	assign ctrl.scan   = (state_q == S_SCAN);
	assign ctrl.finish = (state_q == S_DONE) && sts.out_free;

endmodule

`default_nettype wire

// ===== src/fpst_dp.sv =====
// Datapath with the pair memory, scan pipeline, counters and result register.
`default_nettype none

module fpst_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire fpst_pkg::ctrl_cmd_t                ctrl,
	output fpst_pkg::ctrl_sts_t                     sts,
	input  wire logic                               req_cmd,
	input  wire logic [fpst_pkg::FMT_W-1:0]         req_format,
	input  wire logic [fpst_pkg::MOD_W-1:0]         req_modifier,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [2:0]                              out_status,
	output logic                                    out_present,
	output logic [fpst_pkg::ENTRY_W-1:0]            out_count,
	output logic                                    out_overflow
);

	`include "filtered_pair_set_table_assert.svh"

	logic [fpst_pkg::PAIR_W-1:0] mem [fpst_pkg::MAX_PAIRS];

	logic                          cmd_q;
	logic [fpst_pkg::PAIR_W-1:0]   pair_q;
	logic [fpst_pkg::CNT_W-1:0]    idx_q;
	logic [fpst_pkg::CNT_W-1:0]    fill_q;
	logic                          ovf_q;
	logic                          hit_q;
	logic                          rd_vld_s1;
	logic [fpst_pkg::PAIR_W-1:0]   rd_data_s1;
	logic                          out_valid_q;
	fpst_pkg::status_t             out_status_q;
	logic                          out_present_q;
	logic [fpst_pkg::ENTRY_W-1:0]  out_count_q;
	logic                          out_ovf_q;

	logic                          rd_en;
	logic                          wr_en;
	logic                          full;
	fpst_pkg::status_t             status_nxt;
	logic [fpst_pkg::CNT_W-1:0]    fill_nxt;
	logic                          ovf_nxt;

	assign rd_en = ctrl.scan && (idx_q < fill_q);
	assign full  = (fill_q >= fpst_pkg::CNT_W'(fpst_pkg::MAX_PAIRS));

	always_comb begin
		status_nxt = fpst_pkg::ST_STORED;
		fill_nxt   = fill_q;
		ovf_nxt    = ovf_q;
		wr_en      = 1'b0;
		if (cmd_q == fpst_pkg::CMD_QUERY) begin
			status_nxt = fpst_pkg::ST_QUERY;
		end else if (!fpst_pkg::fmt_known(pair_q[fpst_pkg::FMT_W-1:0])) begin
			status_nxt = fpst_pkg::ST_UNSUPPORTED;
		end else if (hit_q) begin
			status_nxt = fpst_pkg::ST_DUPLICATE;
		end else if (full) begin
			status_nxt = fpst_pkg::ST_FULL;
			ovf_nxt    = 1'b1;
		end else begin
			status_nxt = fpst_pkg::ST_STORED;
			fill_nxt   = fill_q + fpst_pkg::CNT_W'(1);
			wr_en      = ctrl.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[fill_q[fpst_pkg::ADDR_W-1:0]] <= pair_q;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[idx_q[fpst_pkg::ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q  <= req_cmd;
			pair_q <= {req_modifier, req_format};
		end
		if (ctrl.finish) begin
			out_status_q  <= status_nxt;
			out_present_q <= hit_q;
			out_count_q   <= fpst_pkg::ENTRY_W'(fill_nxt);
			out_ovf_q     <= ovf_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			hit_q       <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (ctrl.load) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (rd_en) idx_q <= idx_q + fpst_pkg::CNT_W'(1);
				if (rd_vld_s1 && (rd_data_s1 == pair_q)) hit_q <= 1'b1;
			end
			if (ctrl.finish) begin
				fill_q      <= fill_nxt;
				ovf_q       <= ovf_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.scan_done = !rd_vld_s1 && (idx_q >= fill_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign out_status   = out_status_q;
	assign out_present  = out_present_q;
	assign out_count    = out_count_q;
	assign out_overflow = out_ovf_q;

	`FPST_ASSERT_SAME(a_fill_bound, 1'b1, fill_q <= fpst_pkg::CNT_W'(fpst_pkg::MAX_PAIRS))
	`FPST_ASSERT_NEXT(a_ovf_sticky, ovf_q, ovf_q)
	`FPST_ASSERT_SAME(a_write_room, wr_en, !full)
	`FPST_ASSERT_SAME(a_read_stored, rd_en, idx_q < fill_q)
	`FPST_ASSERT_SAME(a_finish_after_scan, ctrl.finish, !rd_vld_s1 && !rd_en)

endmodule

`default_nettype wire

// ===== src/filtered_pair_set_table.sv =====
// Top level of the filtered pair set table: stream ports, controller and datapath.
// An item is accepted only in idle; the controller then scans the table, reading one
// stored pair per cycle from the memory, and writes the result into the output register
// once it is free. The next item is not accepted until that result has been written.
// A waiting result sits in an output register while the next item is accepted.
// The asynchronous reset empties the table and clears the overflow flag; the
// pair memory itself is not reset, since only written entries are ever read.
`default_nettype none

module filtered_pair_set_table (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// format_code [31:0], layout_modifier [95:32]
	input  wire logic [fpst_pkg::IN_DATA_W-1:0]      s_tdata,
	// cmd [0]
	input  wire logic [0:0]                          s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// add_status [2:0], present [3], entry_count [12:4], overflow_seen [13], zeros above
	output logic [fpst_pkg::OUT_DATA_W-1:0]          m_tdata
);

	fpst_pkg::ctrl_cmd_t ctrl;
	fpst_pkg::ctrl_sts_t sts;

	logic [2:0]                       out_status;
	logic                             out_present;
	logic [fpst_pkg::ENTRY_W-1:0]     out_count;
	logic                             out_overflow;

	fpst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.ctrl     (ctrl),
		.sts      (sts)
	);

	fpst_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.sts          (sts),
		.req_cmd      (s_tuser[0]),
		.req_format   (s_tdata[fpst_pkg::FMT_W-1:0]),
		.req_modifier (s_tdata[fpst_pkg::PAIR_W-1:fpst_pkg::FMT_W]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_status   (out_status),
		.out_present  (out_present),
		.out_count    (out_count),
		.out_overflow (out_overflow)
	);

	assign m_tdata = fpst_pkg::OUT_DATA_W'({out_overflow, out_count, out_present, out_status});

endmodule

`default_nettype wire

// ===== sim/filtered_pair_set_table_tb.sv =====
// Testbench for the filtered pair set table: directed and random requests checked against a predictor.
module filtered_pair_set_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 300;
	localparam int FILL_GUARD   = 700;

	typedef struct {
		fpst_pkg::status_t                status;
		logic                             present;
		logic [fpst_pkg::ENTRY_W-1:0]     count;
		logic                             overflow;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [fpst_pkg::IN_DATA_W-1:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [fpst_pkg::OUT_DATA_W-1:0] m_tdata;

	logic [fpst_pkg::FMT_W-1:0] known_codes [0:3] = '{fpst_pkg::FMT_XR24,
		fpst_pkg::FMT_AR24, fpst_pkg::FMT_XB24, fpst_pkg::FMT_AB24};

	logic [fpst_pkg::FMT_W-1:0] held_format [fpst_pkg::MAX_PAIRS];
	logic [fpst_pkg::MOD_W-1:0] held_modifier [fpst_pkg::MAX_PAIRS];
	int held_count = 0;
	logic overflow_latched = 1'b0;

	table_result_t pending_results[$];
	int fail_count = 0;
	int cycle_count = 0;
	bit no_idle = 1'b0;

	filtered_pair_set_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 8);
	endfunction

	function automatic table_result_t predict_table_result(input fpst_pkg::cmd_t c,
			input logic [fpst_pkg::FMT_W-1:0] f, input logic [fpst_pkg::MOD_W-1:0] m);
		table_result_t r;
		logic hit;
		logic known;
		int k;
		hit = 1'b0;
		known = 1'b0;
		for (k = 0; k < held_count; k++) begin
			if (held_format[k] == f && held_modifier[k] == m)
				hit = 1'b1;
		end
		for (k = 0; k < 4; k++) begin
			if (known_codes[k] == f)
				known = 1'b1;
		end
		if (c == fpst_pkg::CMD_QUERY) begin
			r.status = fpst_pkg::ST_QUERY;
		end else if (!known) begin
			r.status = fpst_pkg::ST_UNSUPPORTED;
		end else if (hit) begin
			r.status = fpst_pkg::ST_DUPLICATE;
		end else if (held_count >= fpst_pkg::MAX_PAIRS) begin
			overflow_latched = 1'b1;
			r.status = fpst_pkg::ST_FULL;
		end else begin
			held_format[held_count] = f;
			held_modifier[held_count] = m;
			held_count++;
			r.status = fpst_pkg::ST_STORED;
		end
		r.present = hit;
		r.count = fpst_pkg::ENTRY_W'(held_count);
		r.overflow = overflow_latched;
		return r;
	endfunction

	task automatic send_request(input fpst_pkg::cmd_t c, input logic [fpst_pkg::FMT_W-1:0] f,
			input logic [fpst_pkg::MOD_W-1:0] m);
		int gap;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c;
		s_tdata <= {m, f};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(predict_table_result(c, f, m));
	endtask

	task automatic send_random_request(input int fresh_pct);
		logic [fpst_pkg::FMT_W-1:0] f;
		logic [fpst_pkg::MOD_W-1:0] m;
		fpst_pkg::cmd_t c;
		int slot;
		f = known_codes[$urandom_range(0, 3)];
		m = ($urandom_range(0, 7) == 0) ? fpst_pkg::MOD_W'($urandom_range(0, 15)) :
			{$urandom, $urandom};
		c = fpst_pkg::CMD_ADD;
		if ($urandom_range(0, 99) >= fresh_pct) begin
			slot = (held_count > 0) ? $urandom_range(0, held_count - 1) : 0;
			case ($urandom_range(0, 4))
				0: begin
					if (held_count > 0) begin
						f = held_format[slot];
						m = held_modifier[slot];
					end
				end
				1: begin
					c = fpst_pkg::CMD_QUERY;
					if (held_count > 0) begin
						f = held_format[slot];
						m = held_modifier[slot];
					end
				end
				2: begin
					if ($urandom_range(0, 1))
						f = $urandom;
					else
						f = f ^ (fpst_pkg::FMT_W'(1) << $urandom_range(0, fpst_pkg::FMT_W - 1));
				end
				3: begin
					c = fpst_pkg::CMD_QUERY;
					if ($urandom_range(0, 1))
						f = $urandom;
				end
				default: begin
					if (held_count > 0) begin
						f = held_format[slot];
						m = held_modifier[slot] ^
							(fpst_pkg::MOD_W'(1) << $urandom_range(0, fpst_pkg::MOD_W - 1));
					end
				end
			endcase
		end
		send_request(c, f, m);
	endtask

	task automatic test_format_filter();
		send_request(fpst_pkg::CMD_QUERY, fpst_pkg::FMT_XR24, '0);
		send_request(fpst_pkg::CMD_ADD, '0, '0);
		send_request(fpst_pkg::CMD_ADD, {fpst_pkg::FMT_W{1'b1}}, {fpst_pkg::MOD_W{1'b1}});
		send_request(fpst_pkg::CMD_ADD, fpst_pkg::FMT_XR24 ^ 32'h1, '0);
		send_request(fpst_pkg::CMD_ADD, fpst_pkg::FMT_XR24, '0);
		send_request(fpst_pkg::CMD_ADD, fpst_pkg::FMT_AR24, {fpst_pkg::MOD_W{1'b1}});
		send_request(fpst_pkg::CMD_ADD, fpst_pkg::FMT_XB24, 64'h00FF_00FF_00FF_00FF);
		send_request(fpst_pkg::CMD_ADD, fpst_pkg::FMT_AB24, 64'h8000_0000_0000_0001);
	endtask

	task automatic test_duplicates();
		send_request(fpst_pkg::CMD_ADD, fpst_pkg::FMT_XR24, '0);
		send_request(fpst_pkg::CMD_ADD, fpst_pkg::FMT_AR24, {fpst_pkg::MOD_W{1'b1}});
		send_request(fpst_pkg::CMD_ADD, fpst_pkg::FMT_AR24, '0);
		send_request(fpst_pkg::CMD_ADD, fpst_pkg::FMT_XR24, 64'h1);
		send_request(fpst_pkg::CMD_ADD, fpst_pkg::FMT_XR24, 64'h1);
		send_request(fpst_pkg::CMD_ADD, fpst_pkg::FMT_AB24, 64'h8000_0000_0000_0000);
	endtask

	task automatic test_queries();
		send_request(fpst_pkg::CMD_QUERY, fpst_pkg::FMT_XR24, '0);
		send_request(fpst_pkg::CMD_QUERY, fpst_pkg::FMT_AB24, '0);
		send_request(fpst_pkg::CMD_QUERY, fpst_pkg::FMT_XB24, 64'h00FF_00FF_00FF_00FF);
		send_request(fpst_pkg::CMD_QUERY, {fpst_pkg::FMT_W{1'b1}}, {fpst_pkg::MOD_W{1'b1}});
		send_request(fpst_pkg::CMD_QUERY, fpst_pkg::FMT_XB24 ^ 32'h8000_0000,
			64'h00FF_00FF_00FF_00FF);
	endtask

	task automatic test_random_fill();
		int n;
		n = 0;
		while (held_count < fpst_pkg::MAX_PAIRS && n < FILL_GUARD) begin
			if (n % 32 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			send_random_request(60);
			n++;
		end
		no_idle = 1'b0;
	endtask

	task automatic test_full_table();
		int n;
		send_request(fpst_pkg::CMD_ADD, fpst_pkg::FMT_AB24, {$urandom, $urandom});
		send_request(fpst_pkg::CMD_ADD, held_format[0], held_modifier[0]);
		send_request(fpst_pkg::CMD_ADD, held_format[fpst_pkg::MAX_PAIRS - 1],
			held_modifier[fpst_pkg::MAX_PAIRS - 1]);
		send_request(fpst_pkg::CMD_QUERY, held_format[fpst_pkg::MAX_PAIRS / 2],
			held_modifier[fpst_pkg::MAX_PAIRS / 2]);
		send_request(fpst_pkg::CMD_ADD, 32'h1234_5678, {fpst_pkg::MOD_W{1'b1}});
		for (n = 0; n < 60; n++) begin
			if (n % 20 == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			send_random_request(40);
		end
		no_idle = 1'b0;
	endtask

	task automatic check_table_result(input logic [fpst_pkg::OUT_DATA_W-1:0] word);
		table_result_t want;
		if (pending_results.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("result with no request waiting: %h", word);
			return;
		end
		want = pending_results.pop_front();
		if (word[2:0] !== want.status || word[3] !== want.present ||
				word[12:4] !== want.count || word[13] !== want.overflow) begin
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch: status %0d/%0d present %0d/%0d count %0d/%0d overflow %0d/%0d",
					want.status, word[2:0], want.present, word[3],
					want.count, word[12:4], want.overflow, word[13]);
		end
	endtask

	initial begin
		int gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			gap = draw_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			check_table_result(m_tdata);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("filtered_pair_set_table regression: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_format_filter();
		test_duplicates();
		test_queries();
		test_random_fill();
		test_full_table();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("filtered_pair_set_table regression: pass");
		else
			$display("filtered_pair_set_table regression: fail");
		$finish;
	end

endmodule
